>>> rtl/core/ubsd_pkg.sv
// ----------------------------------------------------------------------------
// ubsd_pkg
// Shared types and codes of the Unicode byte stream decoder.
// ----------------------------------------------------------------------------
package ubsd_pkg;

  // encoding codes
  localparam logic [2:0] EncAscii  = 3'd0;
  localparam logic [2:0] EncUtf8   = 3'd1;
  localparam logic [2:0] EncU16Be  = 3'd2;
  localparam logic [2:0] EncU16Le  = 3'd3;
  localparam logic [2:0] EncU32Be  = 3'd4;
  localparam logic [2:0] EncU32Le  = 3'd5;
  localparam logic [2:0] EncDetect = 3'd6;

  // result status codes
  localparam logic [1:0] StCode    = 2'd0;
  localparam logic [1:0] StError   = 2'd1;
  localparam logic [1:0] StEndOk   = 2'd2;
  localparam logic [1:0] StEndFail = 2'd3;

  // up to four replayed prefix bytes plus the end word
  localparam int MaxResults = 5;
  localparam int QueueDepth = 4;

  localparam logic [7:0]  AsciiMax  = 8'h7F;
  localparam logic [7:0]  BomEf     = 8'hEF;
  localparam logic [7:0]  BomBb     = 8'hBB;
  localparam logic [7:0]  BomBf     = 8'hBF;
  localparam logic [7:0]  BomFe     = 8'hFE;
  localparam logic [7:0]  BomFf     = 8'hFF;
  localparam logic [15:0] SurHiMin  = 16'hD800;
  localparam logic [15:0] SurHiMax  = 16'hDBFF;
  localparam logic [15:0] SurLoMin  = 16'hDC00;
  localparam logic [15:0] SurLoMax  = 16'hDFFF;
  localparam logic [31:0] SuppBase  = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] code_point;
    logic [1:0]  status;
  } result_t;

  // all results caused by one input word
  typedef struct packed {
    logic [2:0]                    cnt;
    result_t [MaxResults-1:0]      res;
  } run_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [2:0]  biu;
    logic        hs;
    logic        failed;
  } unit_state_t;

  typedef struct packed {
    unit_state_t s;
    logic        emit;
    result_t     r;
  } feed_out_t;

endpackage

>>> rtl/core/unicode_byte_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// unicode_byte_stream_decoder_top
// Byte stream to Unicode code point decoder with byte-order mark detection.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one byte word per handshake, with
// byte_present and stream_end. Output channel (out_valid/out_ready): one
// result word per handshake: code_point, status, last_of_run marking the
// final result caused by one input word. Config channel (cfg_valid/
// cfg_ready, encoding_mode) is always ready; write it only while idle.
// Throughput: one input word per cycle while the run queue has room; the
// output side gives one result per cycle while out_ready is high, so an
// input word causing k results (k is at most 5) holds it until all k go.
// The queue slot is written at the edge that takes the word; the output
// register in the back loads from the queue once the back is free, and
// the first result of the word is presented from that register.
// Reset: the mode returns to detect, all stream state and the queue clear.
// A stalled receiver backs up the queue; in_ready drops only once the queue
// (QUEUE_DEPTH runs) is full.
// ----------------------------------------------------------------------------
module unicode_byte_stream_decoder_top #(
  parameter int QUEUE_DEPTH = ubsd_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  encoding_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        byte_present,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] code_point,
  output logic [1:0]  status,
  output logic        last_of_run
);
  import ubsd_pkg::*;

  logic push;
  run_t push_run;
  logic q_ready;
  logic q_pop;
  logic q_valid;
  run_t q_run;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready;

  ubsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_mode     (encoding_mode),
    .in_valid     (in_valid),
    .q_ready      (q_ready),
    .byte_value   (byte_value),
    .byte_present (byte_present),
    .stream_end   (stream_end),
    .push         (push),
    .push_run     (push_run)
  );

  ubsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_run  (push_run),
    .ready     (q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_run   (q_run)
  );

  ubsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_run       (q_run),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .status      (status),
    .last_of_run (last_of_run)
  );

endmodule

>>> rtl/core/ubsd_front.sv
// ----------------------------------------------------------------------------
// ubsd_front
// Accepts bytes, tracks stream state, detects the byte-order mark and
// decodes units; pushes the results of each input word as one run.
// ----------------------------------------------------------------------------
module ubsd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [2:0]       cfg_mode,
  input  logic             in_valid,
  input  logic             q_ready,
  input  logic [7:0]       byte_value,
  input  logic             byte_present,
  input  logic             stream_end,
  output logic             push,
  output ubsd_pkg::run_t   push_run
);
  import ubsd_pkg::*;

  localparam unit_state_t Clean = '{acc: 32'd0, biu: 3'd0, hs: 1'b0, failed: 1'b0};

  function automatic logic [2:0] utf8_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7:5] == 3'b110) len = 3'd2;
    else if (b[7:4] == 4'b1110) len = 3'd3;
    else if (b[7:3] == 5'b11110) len = 3'd4;
    return len;
  endfunction

  function automatic feed_out_t feed(input logic [2:0] enc, input unit_state_t s,
                                     input logic [7:0] b);
    feed_out_t   o;
    logic [31:0] acc_n;
    logic [2:0]  biu_n;
    logic [7:0]  lead;
    logic [2:0]  need;
    logic [15:0] raw;
    logic [15:0] cu16;
    logic [15:0] hsv;
    o.s            = s;
    o.emit         = 1'b0;
    o.r.code_point = 32'd0;
    o.r.status     = StCode;
    acc_n          = {s.acc[23:0], b};
    biu_n          = s.biu + 3'd1;
    lead           = 8'd0;
    need           = 3'd0;
    raw            = acc_n[15:0];
    cu16           = 16'd0;
    hsv            = acc_n[31:16];
    unique case (enc)
      EncAscii: begin
        o.emit = 1'b1;
        if (b > AsciiMax) begin
          o.r.status = StError;
          o.s        = Clean;
          o.s.failed = 1'b1;
        end else begin
          o.r.code_point = {24'd0, b};
        end
      end
      EncUtf8: begin
        if (s.biu == 3'd0) begin
          if (!b[7]) begin
            o.emit         = 1'b1;
            o.r.code_point = {24'd0, b};
          end else if (utf8_len(b) == 3'd0) begin
            o.emit     = 1'b1;
            o.r.status = StError;
            o.s        = Clean;
            o.s.failed = 1'b1;
          end else begin
            o.s.acc = {24'd0, b};
            o.s.biu = 3'd1;
          end
        end else begin
          unique case (s.biu)
            3'd1:    lead = s.acc[7:0];
            3'd2:    lead = s.acc[15:8];
            default: lead = s.acc[23:16];
          endcase
          need    = utf8_len(lead);
          o.s.acc = acc_n;
          o.s.biu = biu_n;
          if (biu_n >= need) begin
            unique case (need)
              3'd2: o.r.code_point = {21'd0, lead[4:0], acc_n[5:0]};
              3'd3: o.r.code_point = {16'd0, lead[3:0], acc_n[13:8], acc_n[5:0]};
              3'd4: o.r.code_point = {11'd0, lead[2:0], acc_n[21:16], acc_n[13:8],
                                      acc_n[5:0]};
              default: o.r.code_point = {25'd0, lead[6:0]};
            endcase
            o.emit = 1'b1;
            o.s    = Clean;
          end
        end
      end
      EncU16Be, EncU16Le: begin
        o.s.acc = acc_n;
        o.s.biu = biu_n;
        if (biu_n >= 3'd2) begin
          cu16    = (enc == EncU16Be) ? raw : {raw[7:0], raw[15:8]};
          o.s.biu = 3'd0;
          if (s.hs) begin
            o.s    = Clean;
            o.emit = 1'b1;
            if (cu16 < SurLoMin || cu16 > SurLoMax) begin
              o.r.status = StError;
              o.s.failed = 1'b1;
            end else begin
              // high and low ten bits joined above the BMP
              o.r.code_point = SuppBase + {12'd0, hsv[9:0], cu16[9:0]};
            end
          end else if (cu16 >= SurHiMin && cu16 <= SurHiMax) begin
            o.s.hs  = 1'b1;
            o.s.acc = {16'd0, cu16};
          end else begin
            o.s.acc        = 32'd0;
            o.emit         = 1'b1;
            o.r.code_point = {16'd0, cu16};
          end
        end
      end
      default: begin
        o.s.acc = acc_n;
        o.s.biu = biu_n;
        if (biu_n >= 3'd4) begin
          o.r.code_point = (enc == EncU32Be) ? acc_n :
                           {acc_n[7:0], acc_n[15:8], acc_n[23:16], acc_n[31:24]};
          o.emit = 1'b1;
          o.s    = Clean;
        end
      end
    endcase
    return o;
  endfunction

  logic [2:0]      mode;
  logic [2:0]      active;
  logic [7:0]      prefix [4];
  logic [2:0]      count;
  unit_state_t     ust;

  logic            accept;
  logic            detect;
  logic            take_byte;
  logic [7:0]      held_w [4];
  logic [2:0]      n_w;
  logic            do_resolve;
  logic [2:0]      enc_r;
  logic            is_u16_r;
  logic            feed_use_r;
  unit_state_t     preset;
  logic [2:0]      feed_enc;
  unit_state_t     feed_st;
  logic [7:0]      feed_b;
  feed_out_t       fo;
  logic            a_fail;
  logic [2:0]      cnt_a;
  unit_state_t     st_a;
  logic [2:0]      active_a;
  logic [2:0]      count_a;
  logic            bad;
  result_t         end_res;
  run_t            run;
  logic [2:0]      start_enc;

  assign accept    = in_valid && q_ready;
  assign detect    = (active == EncDetect);
  assign take_byte = byte_present && !ust.failed;
  assign start_enc = (mode >= EncDetect) ? EncDetect : mode;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      held_w[i] = (detect && take_byte && count[1:0] == 2'(i)) ? byte_value : prefix[i];
    end
    n_w        = count + ((detect && take_byte) ? 3'd1 : 3'd0);
    do_resolve = detect && (n_w == 3'd4 || stream_end);

    // byte-order mark rules, size limits as specified
    enc_r = EncAscii;
    if (n_w >= 3'd2) begin
      priority if (held_w[0] == BomEf) begin
        if (n_w > 3'd3 && held_w[1] == BomBb && held_w[2] == BomBf) enc_r = EncUtf8;
      end else if (held_w[0] == BomFe) begin
        if (n_w > 3'd2 && held_w[1] == BomFf) enc_r = EncU16Be;
      end else if (held_w[0] == 8'h00) begin
        if (n_w >= 3'd4 && held_w[1] == 8'h00 && held_w[2] == BomFe &&
            held_w[3] == BomFf) enc_r = EncU32Be;
      end else if (held_w[0] == BomFf) begin
        if (held_w[1] == BomFe) begin
          if (n_w >= 3'd4 && held_w[2] == 8'h00 && held_w[3] == 8'h00) enc_r = EncU32Le;
          else enc_r = EncU16Le;
        end
      end else begin
        enc_r = EncAscii;
      end
    end
    is_u16_r   = (enc_r == EncU16Be) || (enc_r == EncU16Le);
    feed_use_r = (enc_r == EncUtf8) || (is_u16_r && n_w == 3'd4);

    // first byte after a 16-bit mark is already half a unit
    preset     = Clean;
    preset.acc = {24'd0, held_w[2]};
    preset.biu = 3'd1;

    feed_enc = detect ? enc_r : active;
    feed_st  = detect ? ((enc_r == EncUtf8) ? Clean : preset) : ust;
    feed_b   = detect ? held_w[3] : byte_value;
    fo       = feed(feed_enc, feed_st, feed_b);

    run.cnt = 3'd0;
    for (int j = 0; j < MaxResults; j++) begin
      run.res[j] = '{code_point: 32'd0, status: StCode};
    end
    a_fail   = 1'b0;
    cnt_a    = 3'd0;
    st_a     = ust;
    active_a = active;
    count_a  = count;

    if (do_resolve) begin
      active_a = enc_r;
      count_a  = 3'd0;
      if (enc_r == EncAscii) begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < n_w && !a_fail) begin
            if (held_w[i] > AsciiMax) begin
              run.res[i].status = StError;
              a_fail            = 1'b1;
            end else begin
              run.res[i].code_point = {24'd0, held_w[i]};
            end
            cnt_a = cnt_a + 3'd1;
          end
        end
        st_a        = Clean;
        st_a.failed = a_fail;
      end else if (feed_use_r) begin
        st_a       = fo.s;
        run.res[0] = fo.r;
        cnt_a      = fo.emit ? 3'd1 : 3'd0;
      end else if (is_u16_r && n_w == 3'd3) begin
        st_a = preset;
      end else begin
        st_a = Clean;
      end
    end else if (detect) begin
      count_a = n_w;
    end else if (take_byte) begin
      st_a       = fo.s;
      run.res[0] = fo.r;
      cnt_a      = fo.emit ? 3'd1 : 3'd0;
    end

    bad     = st_a.failed || st_a.biu != 3'd0 || st_a.hs;
    end_res = '{code_point: 32'd0, status: (bad ? StEndFail : StEndOk)};
    run.cnt = cnt_a;
    if (stream_end) begin
      for (int j = 0; j < MaxResults; j++) begin
        if (3'(j) == cnt_a) run.res[j] = end_res;
      end
      run.cnt = cnt_a + 3'd1;
    end
  end

  assign push     = accept && (run.cnt != 3'd0);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= EncDetect;
      active <= EncDetect;
      count  <= 3'd0;
      ust    <= Clean;
    end else if (cfg_valid) begin
      mode   <= cfg_mode;
      active <= (cfg_mode >= EncDetect) ? EncDetect : cfg_mode;
      count  <= 3'd0;
      ust    <= Clean;
    end else if (accept) begin
      if (stream_end) begin
        active <= start_enc;
        count  <= 3'd0;
        ust    <= Clean;
      end else begin
        active <= active_a;
        count  <= count_a;
        ust    <= st_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && detect && take_byte) begin
      prefix[count[1:0]] <= byte_value;
    end
  end

endmodule

>>> rtl/core/ubsd_queue.sv
// ----------------------------------------------------------------------------
// ubsd_queue
// Short FIFO of result runs between the front and the back.
// ----------------------------------------------------------------------------
module ubsd_queue #(
  parameter int DEPTH = ubsd_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ubsd_pkg::run_t push_run,
  output logic           ready,
  input  logic           pop,
  output logic           pop_valid,
  output ubsd_pkg::run_t pop_run
);
  import ubsd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastIdx = PW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  run_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign ready     = (fill != Full);
  assign pop_valid = (fill != '0);
  assign pop_run   = slots[rd_ptr];
  assign do_push   = push && ready;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_run;
  end

endmodule

>>> rtl/core/ubsd_back.sv
// ----------------------------------------------------------------------------
// ubsd_back
// Takes runs from the queue and presents their results one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ubsd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ubsd_pkg::run_t q_run,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    code_point,
  output logic [1:0]     status,
  output logic           last_of_run
);
  import ubsd_pkg::*;

  logic       busy;
  run_t       cur;
  logic [2:0] idx;
  logic       last;
  logic       advance;

  assign last        = (idx == cur.cnt - 3'd1);
  assign advance     = busy && out_ready;
  assign q_pop       = q_valid && (!busy || (advance && last));
  assign out_valid   = busy;
  assign code_point  = cur.res[idx].code_point;
  assign status      = cur.res[idx].status;
  assign last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (advance) begin
      if (last) busy <= 1'b0;
      else idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_run;
  end

endmodule
